// ===== design/station_learning_table_unit_assert.svh =====
// ----------------------------------------------------------------------------
// station learning table assertion macros
// concurrent assertion shorthands clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef STATION_LEARNING_TABLE_UNIT_ASSERT_SVH
`define STATION_LEARNING_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define SLT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("station learning table: same-cycle check failed");

// next-cycle implication
`define SLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("station learning table: next-cycle check failed");

`endif

// ===== design/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg
// shared codes, field widths and the table entry type
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int MAC_W     = 48;
    localparam int RSSI_W    = 8;
    localparam int IDX_OUT_W = 5;
    localparam int CNT_OUT_W = 6;

    // request codes
    localparam logic [1:0] REQ_FRAME = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // status codes
    localparam logic [2:0] ST_IGNORED   = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_ADDED     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_READ_OK   = 3'd4;
    localparam logic [2:0] ST_READ_OOR  = 3'd5;
    localparam logic [2:0] ST_CLEARED   = 3'd6;

    typedef struct packed {
        logic [MAC_W-1:0]         mac;
        logic signed [RSSI_W-1:0] rssi;
    } slt_entry_t;

endpackage

// ===== design/slt_station_store.sv =====
// ----------------------------------------------------------------------------
// slt_station_store
// station entry memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module slt_station_store #(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  slt_pkg::slt_entry_t wr_entry,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_addr,
    output slt_pkg::slt_entry_t rd_entry
);
    import slt_pkg::*;

    slt_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry <= mem[rd_addr];
        end
    end

endmodule

// ===== design/station_learning_table_unit.sv =====
// ----------------------------------------------------------------------------
// station_learning_table_unit
// learns station macs and their last rssi from management frames of one ap
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                  payload
// item      in         item_valid / item_ready    req_type .. read_index
// result    out        result_valid / result_ready status .. client_count
// config    in         apb psel/penable/pwrite    home bssid at byte address 0
//
// steps: a frame request is accepted, its bssid checked, then one stored entry
//   per cycle is compared through the single memory read port until a hit or
//   the last valid entry; a read goes through the check and one memory read, a
//   clear or filtered frame through the check only; then the result moves into the output register
// stalls: item_ready is high only while the sequencer is idle; a finished
//   result waits in the sequencer while the output register is still held
// reset: clears the sequencer, the entry count and the tracked bssid; the
//   entry memory is not cleared since no entry at or above the count is read
//
`include "station_learning_table_unit_assert.svh"

module station_learning_table_unit #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic [1:0]                      req_type,
    input  logic                            frame_is_mgmt,
    input  logic [slt_pkg::MAC_W-1:0]       frame_bssid,
    input  logic [slt_pkg::MAC_W-1:0]       source_mac,
    input  logic signed [slt_pkg::RSSI_W-1:0] frame_rssi,
    input  logic [slt_pkg::IDX_OUT_W-1:0]   read_index,
    // result channel
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [2:0]                      status,
    output logic [slt_pkg::IDX_OUT_W-1:0]   entry_index,
    output logic [slt_pkg::MAC_W-1:0]       entry_mac,
    output logic signed [slt_pkg::RSSI_W-1:0] entry_rssi,
    output logic [slt_pkg::CNT_OUT_W-1:0]   client_count,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready
);
    import slt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > IDX_OUT_W) ? CNT_W : IDX_OUT_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [IDX_W-1:0]        scan_reg, scan_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [MAC_W-1:0]        home_bssid_reg;

    // latched request
    logic [1:0]              req_type_reg;
    logic                    frame_is_mgmt_reg;
    logic [MAC_W-1:0]        frame_bssid_reg;
    logic [MAC_W-1:0]        source_mac_reg;
    logic signed [RSSI_W-1:0] frame_rssi_reg;
    logic [IDX_OUT_W-1:0]    read_index_reg;

    // pending result
    logic [2:0]              res_status_reg, res_status_next;
    logic [IDX_OUT_W-1:0]    res_index_reg, res_index_next;
    logic [MAC_W-1:0]        res_mac_reg, res_mac_next;
    logic signed [RSSI_W-1:0] res_rssi_reg, res_rssi_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic                    out_load;
    logic [2:0]              status_reg;
    logic [IDX_OUT_W-1:0]    entry_index_reg;
    logic [MAC_W-1:0]        entry_mac_reg;
    logic signed [RSSI_W-1:0] entry_rssi_reg;
    logic [CNT_OUT_W-1:0]    client_count_reg;

    // memory ports
    logic                    mem_wr_en;
    logic [IDX_W-1:0]        mem_wr_addr;
    slt_entry_t              mem_wr_entry;
    logic                    mem_rd_en;
    logic [IDX_W-1:0]        mem_rd_addr;
    slt_entry_t              mem_rd_entry;

    // shared 48-bit compare unit: bssid check first, then one entry per cycle
    logic [MAC_W-1:0]        cmp_a;
    logic [MAC_W-1:0]        cmp_b;
    logic                    cmp_eq;

    logic                    item_accept;
    logic                    cfg_write;
    logic [CMP_W-1:0]        ridx_cmp;
    logic [CMP_W-1:0]        count_cmp;
    logic [CNT_W-1:0]        scan_plus;
    logic                    table_has_room;

    assign item_ready   = (state_reg == S_IDLE);
    assign item_accept  = item_valid && item_ready;
    assign result_valid = out_valid_reg;
    assign status       = status_reg;
    assign entry_index  = entry_index_reg;
    assign entry_mac    = entry_mac_reg;
    assign entry_rssi   = entry_rssi_reg;
    assign client_count = client_count_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[3] == 1'b0) ? {16'b0, home_bssid_reg} : 64'b0;

    assign cmp_a  = (state_reg == S_CHECK) ? frame_bssid_reg : mem_rd_entry.mac;
    assign cmp_b  = (state_reg == S_CHECK) ? home_bssid_reg : source_mac_reg;
    assign cmp_eq = (cmp_a == cmp_b);

    assign ridx_cmp       = CMP_W'(read_index_reg);
    assign count_cmp      = CMP_W'(count_reg);
    assign scan_plus      = CNT_W'(scan_reg) + CNT_W'(1);
    assign table_has_room = (count_reg < CNT_W'(TABLE_DEPTH));

    slt_station_store #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk      (clk),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_entry (mem_wr_entry),
        .rd_en    (mem_rd_en),
        .rd_addr  (mem_rd_addr),
        .rd_entry (mem_rd_entry)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_mac_next    = res_mac_reg;
        res_rssi_next   = res_rssi_reg;
        out_load        = 1'b0;
        out_valid_next  = out_valid_reg && !result_ready;

        mem_wr_en          = 1'b0;
        mem_wr_addr        = scan_reg;
        mem_wr_entry.mac   = source_mac_reg;
        mem_wr_entry.rssi  = frame_rssi_reg;
        mem_rd_en          = 1'b0;
        mem_rd_addr        = IDX_W'(scan_plus);

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                res_index_next = '0;
                res_mac_next   = '0;
                res_rssi_next  = '0;
                state_next     = S_DONE;
                case (req_type_reg)
                    REQ_FRAME:
                    begin
                        if (!frame_is_mgmt_reg || !cmp_eq)
                        begin
                            res_status_next = ST_IGNORED;
                        end
                        else if (count_reg == '0)
                        begin
                            // empty table: append straight away
                            mem_wr_en       = 1'b1;
                            mem_wr_addr     = '0;
                            count_next      = CNT_W'(1);
                            res_status_next = ST_ADDED;
                        end
                        else
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = '0;
                            scan_next   = '0;
                            state_next  = S_SCAN;
                        end
                    end

                    REQ_READ:
                    begin
                        if (ridx_cmp < count_cmp)
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = ridx_cmp[IDX_W-1:0];
                            state_next  = S_READ;
                        end
                        else
                        begin
                            res_status_next = ST_READ_OOR;
                        end
                    end

                    REQ_CLEAR:
                    begin
                        count_next      = '0;
                        res_status_next = ST_CLEARED;
                    end

                    default:
                    begin
                        res_status_next = ST_IGNORED;
                    end
                endcase
            end

            S_SCAN:
            begin
                res_mac_next  = '0;
                res_rssi_next = '0;
                if (cmp_eq)
                begin
                    // hit: refresh rssi of this entry
                    mem_wr_en       = 1'b1;
                    mem_wr_addr     = scan_reg;
                    res_status_next = ST_UPDATED;
                    res_index_next  = IDX_OUT_W'(scan_reg);
                    state_next      = S_DONE;
                end
                else if (scan_plus == count_reg)
                begin
                    // miss on the last valid entry
                    if (table_has_room)
                    begin
                        mem_wr_en       = 1'b1;
                        mem_wr_addr     = count_reg[IDX_W-1:0];
                        count_next      = count_reg + CNT_W'(1);
                        res_status_next = ST_ADDED;
                        res_index_next  = IDX_OUT_W'(count_reg);
                    end
                    else
                    begin
                        res_status_next = ST_FULL;
                        res_index_next  = '0;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    mem_rd_en = 1'b1;
                    scan_next = IDX_W'(scan_plus);
                end
            end

            S_READ:
            begin
                res_status_next = ST_READ_OK;
                res_index_next  = read_index_reg;
                res_mac_next    = mem_rd_entry.mac;
                res_rssi_next   = mem_rd_entry.rssi;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_reg       <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            home_bssid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && (paddr[3] == 1'b0))
            begin
                home_bssid_reg <= pwdata[MAC_W-1:0];
            end
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            req_type_reg      <= req_type;
            frame_is_mgmt_reg <= frame_is_mgmt;
            frame_bssid_reg   <= frame_bssid;
            source_mac_reg    <= source_mac;
            frame_rssi_reg    <= frame_rssi;
            read_index_reg    <= read_index;
        end
    end

    // pending result and output register
    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_mac_reg    <= res_mac_next;
        res_rssi_reg   <= res_rssi_next;
        if (out_load)
        begin
            status_reg       <= res_status_reg;
            entry_index_reg  <= res_index_reg;
            entry_mac_reg    <= res_mac_reg;
            entry_rssi_reg   <= res_rssi_reg;
            client_count_reg <= CNT_OUT_W'(count_reg);
        end
    end

    // an accepted request always moves to the check state next
    `SLT_ASSERT_NEXT(a_accept_to_check, item_accept, state_reg == S_CHECK)
    // the table is written only while a frame is decided
    `SLT_ASSERT_IMPL(a_write_in_decision, mem_wr_en,
        (state_reg == S_CHECK) || (state_reg == S_SCAN))
    // the entry count never passes the table depth
    `SLT_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH))
    // the scan never walks past the valid entries
    `SLT_ASSERT_IMPL(a_scan_bound, state_reg == S_SCAN, CNT_W'(scan_reg) < count_reg)

endmodule
